### hdl/spq_pkg.sv
`timescale 1ns / 1ps
// spq_pkg: shared types, widths and codes for the stable priority queue.
// No dependencies; used by spq_cell, stable_priority_queue_top and spq_checker.

package spq_pkg;

  localparam int PRI_W           = 8;
  localparam int PAY_W           = 16;
  localparam int LEN_W           = 5;
  localparam int STATUS_W        = 2;
  localparam int DEF_QUEUE_DEPTH = 16;

  localparam int IN_DATA_W  = 24;  // priority + payload
  localparam int OUT_DATA_W = 32;  // status + priority + payload + length, byte padded

  // request kind carried on in_tuser
  localparam logic REQ_ENQ = 1'b0;
  localparam logic REQ_DEQ = 1'b1;

  // result status
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  // operation broadcast to every cell
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ENQ  = 2'd1;
  localparam logic [1:0] OP_DEQ  = 2'd2;

  typedef struct packed {
    logic             vld;
    logic [PRI_W-1:0] pri;
    logic [PAY_W-1:0] pay;
  } entry_t;

endpackage

### hdl/spq_cell.sv
`timescale 1ns / 1ps
// spq_cell: one slot of the sorted shift-register queue.
// Depends on spq_pkg (entry_t, OP_* codes).

module spq_cell (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [1:0]              op,
  input  logic [spq_pkg::PRI_W-1:0] new_pri,
  input  logic [spq_pkg::PAY_W-1:0] new_pay,
  input  spq_pkg::entry_t         left_ent,   // neighbor nearer the head
  input  logic                    left_keep,
  input  spq_pkg::entry_t         right_ent,  // neighbor nearer the tail
  output spq_pkg::entry_t         cur_ent,
  output logic                    keep
);

  logic                      vld_r, vld_nxt;
  logic [spq_pkg::PRI_W-1:0] pri_r, pri_nxt;
  logic [spq_pkg::PAY_W-1:0] pay_r, pay_nxt;

  // keep: this slot stays ahead of the new entry (ties keep arrival order)
  assign keep    = vld_r && (pri_r >= new_pri);
  assign cur_ent = '{vld: vld_r, pri: pri_r, pay: pay_r};

  always_comb begin
    vld_nxt = vld_r;
    pri_nxt = pri_r;
    pay_nxt = pay_r;
    unique case (op)
      spq_pkg::OP_ENQ: begin
        if (!keep) begin
          if (left_keep) begin
            vld_nxt = 1'b1;
            pri_nxt = new_pri;
            pay_nxt = new_pay;
          end else begin
            vld_nxt = left_ent.vld;
            pri_nxt = left_ent.pri;
            pay_nxt = left_ent.pay;
          end
        end
      end
      spq_pkg::OP_DEQ: begin
        vld_nxt = right_ent.vld;
        pri_nxt = right_ent.pri;
        pay_nxt = right_ent.pay;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
    pri_r <= pri_nxt;
    pay_r <= pay_nxt;
  end

endmodule

### hdl/stable_priority_queue_top.sv
`timescale 1ns / 1ps
// stable_priority_queue_top: stable sorted priority queue built as a chain of spq_cell slots.
// Depends on spq_pkg and spq_cell.
//
//  channel | dir | tdata fields (low bit up)                           | tuser
//  in_     | in  | entry_priority[7:0], entry_payload[23:8]            | req_type
//  out_    | out | status[1:0], out_priority[9:2], out_payload[25:10], | -
//          |     | occupancy[30:26], zero[31]                          |
//
// One word per cycle unless the output stalls: every cell compares its slot with the broadcast
// entry and loads itself, its neighbor or the new entry in the same cycle the word is taken.
// The result sits in an output register; a new word is taken when it is empty or
// being drained, so a stalled output holds the input off after one word.
// Synchronous active-low reset empties the queue and clears the output valid.

module stable_priority_queue_top #(
  parameter int QUEUE_DEPTH = spq_pkg::DEF_QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [spq_pkg::IN_DATA_W-1:0]     in_tdata,   // entry_priority, entry_payload
  input  logic                              in_tuser,   // req_type
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [spq_pkg::OUT_DATA_W-1:0]    out_tdata   // status, out_priority, out_payload, occupancy
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  logic                      accept;
  logic [1:0]                op;
  logic [spq_pkg::PRI_W-1:0] new_pri;
  logic [spq_pkg::PAY_W-1:0] new_pay;
  logic                      is_empty, is_full;

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_vld_r;
  logic [spq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;
  logic [spq_pkg::STATUS_W-1:0]   status;
  logic [spq_pkg::PRI_W-1:0]      res_pri;
  logic [spq_pkg::PAY_W-1:0]      res_pay;
  logic [31:0]                    len_ext;

  spq_pkg::entry_t cell_ent  [QUEUE_DEPTH];
  logic            cell_keep [QUEUE_DEPTH];

  assign new_pri   = in_tdata[spq_pkg::PRI_W-1:0];
  assign new_pay   = in_tdata[spq_pkg::PRI_W +: spq_pkg::PAY_W];
  assign in_tready = !out_vld_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign is_empty  = (cnt_r == '0);
  assign is_full   = (cnt_r == CNT_FULL);

  always_comb begin
    op      = spq_pkg::OP_NONE;
    cnt_nxt = cnt_r;
    status  = spq_pkg::ST_OK;
    res_pri = '0;
    res_pay = '0;
    if (in_tuser == spq_pkg::REQ_DEQ) begin
      if (is_empty) begin
        status = spq_pkg::ST_EMPTY;
      end else begin
        op      = spq_pkg::OP_DEQ;
        cnt_nxt = cnt_r - 1'b1;
        res_pri = cell_ent[0].pri;
        res_pay = cell_ent[0].pay;
      end
    end else begin
      if (is_full) begin
        status = spq_pkg::ST_FULL;
      end else begin
        op      = spq_pkg::OP_ENQ;
        cnt_nxt = cnt_r + 1'b1;
      end
    end
    if (!accept) begin
      op      = spq_pkg::OP_NONE;
      cnt_nxt = cnt_r;
    end
    len_ext      = 32'(cnt_nxt);
    out_data_nxt = {1'b0, len_ext[spq_pkg::LEN_W-1:0], res_pay, res_pri, status};
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      spq_pkg::entry_t left_ent, right_ent;
      logic            left_keep;
      if (g == 0) begin : g_head
        assign left_ent  = '0;
        assign left_keep = 1'b1;
      end else begin : g_mid
        assign left_ent  = cell_ent[g-1];
        assign left_keep = cell_keep[g-1];
      end
      if (g == QUEUE_DEPTH - 1) begin : g_tail
        assign right_ent = '0;
      end else begin : g_body
        assign right_ent = cell_ent[g+1];
      end

      spq_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (op),
        .new_pri   (new_pri),
        .new_pay   (new_pay),
        .left_ent  (left_ent),
        .left_keep (left_keep),
        .right_ent (right_ent),
        .cur_ent   (cell_ent[g]),
        .keep      (cell_keep[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      out_vld_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (accept) begin
        out_vld_r <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

endmodule

### hdl/spq_checker.sv
`timescale 1ns / 1ps
// spq_checker: port-level checks for stable_priority_queue_top, bound to the top level.
// Depends on spq_pkg.

module spq_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tvalid,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [spq_pkg::OUT_DATA_W-1:0] out_tdata
);

  logic [1:0]  st;
  logic [7:0]  pri;
  logic [15:0] pay;
  logic [4:0]  len;

  assign st  = out_tdata[1:0];
  assign pri = out_tdata[9:2];
  assign pay = out_tdata[25:10];
  assign len = out_tdata[30:26];

  // stalled word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("output word changed while stalled");

  // error results carry no entry
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st != spq_pkg::ST_OK |-> pri == '0 && pay == '0)
    else $error("error status with nonzero entry");

  // empty dequeue implies an empty queue
  a_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && st == spq_pkg::ST_EMPTY |-> len == '0)
    else $error("empty status with nonzero length");

  // an accepted word shows up next cycle
  a_issue: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted word produced no result");

endmodule

bind stable_priority_queue_top spq_checker u_spq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

### verif/tb_stable_priority_queue_top.sv
`timescale 1ns / 1ps
// tb_stable_priority_queue_top: self-checking bench for the stable priority queue.
// Depends on spq_pkg and stable_priority_queue_top; tracks a shadow sorted queue and
// checks every result word against it under random input gaps and output stalls.

module tb_stable_priority_queue_top;

  localparam int DEPTH       = spq_pkg::DEF_QUEUE_DEPTH;
  localparam int CYCLE_LIMIT = 200000;
  localparam int TAIL_CYCLES = 20;

  typedef struct packed {
    logic [spq_pkg::STATUS_W-1:0] status;
    logic [spq_pkg::PRI_W-1:0]    pri;
    logic [spq_pkg::PAY_W-1:0]    pay;
    logic [spq_pkg::LEN_W-1:0]    len;
  } result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [spq_pkg::IN_DATA_W-1:0]  in_tdata = '0;   // entry_priority, entry_payload
  logic                           in_tuser = spq_pkg::REQ_ENQ;  // req_type
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [spq_pkg::OUT_DATA_W-1:0] out_tdata;  // status, out_priority, out_payload, occupancy

  // shadow of the queue contents, slot 0 is the head
  logic [spq_pkg::PRI_W-1:0] shadow_pri[DEPTH];
  logic [spq_pkg::PAY_W-1:0] shadow_pay[DEPTH];
  int                        shadow_cnt = 0;

  result_t pending_results[$];
  int      mismatches = 0;
  int      cycles = 0;
  int      idle_pct = 0;
  int      stall_pct = 0;

  stable_priority_queue_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL stable_priority_queue_top");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= stall_pct);
  end

  // stable insert behind equal or greater priorities; dequeue pops the head
  task automatic queue_update(input logic req, input logic [spq_pkg::PRI_W-1:0] pri,
                              input logic [spq_pkg::PAY_W-1:0] pay);
    result_t r;
    int      pos;
    r = '0;
    r.status = spq_pkg::ST_OK;
    if (req == spq_pkg::REQ_ENQ) begin
      if (shadow_cnt >= DEPTH) begin
        r.status = spq_pkg::ST_FULL;
      end else begin
        pos = 0;
        while (pos < shadow_cnt && shadow_pri[pos] >= pri) pos++;
        for (int i = shadow_cnt; i > pos; i--) begin
          shadow_pri[i] = shadow_pri[i-1];
          shadow_pay[i] = shadow_pay[i-1];
        end
        shadow_pri[pos] = pri;
        shadow_pay[pos] = pay;
        shadow_cnt++;
      end
    end else begin
      if (shadow_cnt == 0) begin
        r.status = spq_pkg::ST_EMPTY;
      end else begin
        r.pri = shadow_pri[0];
        r.pay = shadow_pay[0];
        for (int i = 1; i < shadow_cnt; i++) begin
          shadow_pri[i-1] = shadow_pri[i];
          shadow_pay[i-1] = shadow_pay[i];
        end
        shadow_cnt--;
      end
    end
    r.len = spq_pkg::LEN_W'(shadow_cnt);
    pending_results.push_back(r);
  endtask

  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tdata[1:0];
      got.pri    = out_tdata[9:2];
      got.pay    = out_tdata[25:10];
      got.len    = out_tdata[30:26];
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word status=%0d pri=%0d pay=%0d len=%0d", $realtime,
                   got.status, got.pri, got.pay, got.len);
      end else begin
        want = pending_results.pop_front();
        if (got.status !== want.status || got.pri !== want.pri ||
            got.pay !== want.pay || got.len !== want.len) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: mismatch exp status=%0d pri=%0d pay=%0d len=%0d, got %0d %0d %0d %0d",
                     $realtime, want.status, want.pri, want.pay, want.len,
                     got.status, got.pri, got.pay, got.len);
        end
      end
    end
  end

  // called right after a rising edge; leaves in_tvalid high on return
  task automatic send_word(input logic req, input logic [spq_pkg::PRI_W-1:0] pri,
                           input logic [spq_pkg::PAY_W-1:0] pay);
    while ($urandom_range(99) < idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {pay, pri};
    do @(posedge clk); while (!in_tready);
    queue_update(req, pri, pay);
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic test_empty_dequeue();
    send_word(spq_pkg::REQ_DEQ, '1, '1);
    send_word(spq_pkg::REQ_DEQ, '0, '0);
  endtask

  task automatic test_order_and_ties();
    send_word(spq_pkg::REQ_ENQ, 8'h00, 16'h0000);
    send_word(spq_pkg::REQ_ENQ, 8'hFF, 16'hFFFF);
    send_word(spq_pkg::REQ_ENQ, 8'hAA, 16'h5555);
    send_word(spq_pkg::REQ_ENQ, 8'h55, 16'hAAAA);
    send_word(spq_pkg::REQ_ENQ, 8'hAA, 16'h1234);  // tie lands behind the first 0xAA
    send_word(spq_pkg::REQ_ENQ, 8'h00, 16'h00FF);
    repeat (6) send_word(spq_pkg::REQ_DEQ, 8'h00, 16'h0000);
    send_word(spq_pkg::REQ_DEQ, 8'h00, 16'h0000);
  endtask

  task automatic test_full_drop();
    for (int i = 0; i < DEPTH; i++)
      send_word(spq_pkg::REQ_ENQ, spq_pkg::PRI_W'($urandom_range(3) * 64),
                spq_pkg::PAY_W'(i));
    send_word(spq_pkg::REQ_ENQ, 8'hFF, 16'hBEEF);
    send_word(spq_pkg::REQ_ENQ, 8'h00, 16'hCAFE);
    drain_results();
    repeat (DEPTH) send_word(spq_pkg::REQ_DEQ, 8'h00, 16'h0000);
  endtask

  task automatic random_phase(input int n, input int in_idle, input int out_stall);
    int                        enq_pct;
    int                        pick;
    logic [spq_pkg::PRI_W-1:0] pri;
    idle_pct  = in_idle;
    stall_pct = out_stall;
    enq_pct   = 50;
    for (int k = 0; k < n; k++) begin
      // bursts that lean to filling or emptying so both ends get hit often
      if (k % 40 == 0) begin
        case ($urandom_range(2))
          0: enq_pct = 80;
          1: enq_pct = 25;
          default: enq_pct = 55;
        endcase
      end
      if (k == n / 2) drain_results();
      pick = $urandom_range(9);
      if (pick < 5)       pri = spq_pkg::PRI_W'($urandom_range(3));
      else if (pick < 8)  pri = spq_pkg::PRI_W'($urandom_range(255));
      else if (pick == 8) pri = '0;
      else                pri = '1;
      send_word(($urandom_range(99) < enq_pct) ? spq_pkg::REQ_ENQ : spq_pkg::REQ_DEQ, pri,
                spq_pkg::PAY_W'($urandom_range(16'hFFFF)));
    end
    drain_results();
  endtask

  task automatic test_random_traffic();
    random_phase(200, 0, 0);
    random_phase(200, 49, 0);
    random_phase(200, 0, 49);
    random_phase(200, 7, 7);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_empty_dequeue();
    test_order_and_ties();
    test_full_drop();
    test_random_traffic();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("PASS stable_priority_queue_top");
    end else begin
      $display("FAIL stable_priority_queue_top");
    end
    $finish;
  end

endmodule
